### src/oskf_pkg.sv
// Package: shared types and constants for the one-shot modifier key filter.
`timescale 1ns / 1ps

package oskf_pkg;

   localparam int KEY_W       = 16;
   localparam int POS_W       = 16;
   localparam int MASK_W      = 8;
   localparam int MOD_IDX_W   = $clog2(MASK_W);
   localparam int PAIR_W      = KEY_W + MASK_W;
   localparam int PAIR_REGS   = 4;
   localparam int MAX_PAIRS   = 4;
   localparam int PAIR_LIMIT  = (MAX_PAIRS < PAIR_REGS) ? MAX_PAIRS : PAIR_REGS;
   localparam int CNT_W       = 3;
   localparam int PAIR_IDX_W  = (PAIR_REGS > 1) ? $clog2(PAIR_REGS) : 1;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = PAIR_W;

   localparam logic [KEY_W-1:0] TAPPABLE_MAX = KEY_W'(16'h00FF);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PAIR_COUNT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_PAIR_BASE  = CSR_IDX_W'(1);

   // action kinds
   localparam logic ACT_RELEASE = 1'b0;
   localparam logic ACT_TAP     = 1'b1;

   typedef struct packed {
      logic             is_press;
      logic [KEY_W-1:0] key_code;
      logic [POS_W-1:0] key_position;
   } req_type;

   typedef struct packed {
      logic                 action_kind;
      logic [MOD_IDX_W-1:0] modifier_index;
      logic [POS_W-1:0]     tap_position;
      logic                 last_of_run;
   } rsp_type;

   typedef struct packed {
      logic              done;
      logic              found;
      logic [MASK_W-1:0] mask;
   } match_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_EMIT
   } state_type;

endpackage

### src/oskf_pair_scan.sv
// Pair scanner: walks the configured pairs with one key comparator per cycle.
`timescale 1ns / 1ps

module oskf_pair_scan (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          start,
   input  logic [oskf_pkg::KEY_W-1:0]                    key_code,
   input  logic [oskf_pkg::CNT_W-1:0]                    pair_count,
   input  logic [oskf_pkg::PAIR_REGS-1:0][oskf_pkg::PAIR_W-1:0] pair_word,
   output oskf_pkg::match_status_type                    status
);

   logic                          active_ff, active_in;
   logic [oskf_pkg::CNT_W-1:0]    idx_ff, idx_in;
   logic [oskf_pkg::CNT_W-1:0]    limit_ff, limit_in;
   logic [oskf_pkg::KEY_W-1:0]    code_ff, code_in;
   logic [oskf_pkg::PAIR_W-1:0]   cur_pair;
   logic                          in_range;
   logic                          hit;
   logic                          scan_end;

   assign in_range = idx_ff < limit_ff;
   assign cur_pair = pair_word[idx_ff[oskf_pkg::PAIR_IDX_W-1:0]];
   assign hit      = in_range && (cur_pair[oskf_pkg::PAIR_W-1:oskf_pkg::MASK_W] == code_ff);
   assign scan_end = hit || !in_range;

   assign status.done  = active_ff && scan_end;
   assign status.found = hit;
   assign status.mask  = cur_pair[oskf_pkg::MASK_W-1:0];

   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      limit_in  = limit_ff;
      code_in   = code_ff;
      if (start) begin
         active_in = 1'b1;
         idx_in    = '0;
         code_in   = key_code;
         // counts past the pair registers saturate
         if (pair_count > oskf_pkg::CNT_W'(oskf_pkg::PAIR_LIMIT)) begin
            limit_in = oskf_pkg::CNT_W'(oskf_pkg::PAIR_LIMIT);
         end else begin
            limit_in = pair_count;
         end
      end else if (active_ff) begin
         if (scan_end) begin
            active_in = 1'b0;
         end else begin
            idx_in = idx_ff + oskf_pkg::CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= '0;
         limit_ff  <= '0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
         limit_ff  <= limit_in;
      end
      code_ff <= code_in;
   end

endmodule

### src/one_shot_modifier_key_filter.sv
// Top level: one-shot modifier key filter with sequencer, pair scan and result register.
`timescale 1ns / 1ps

// One key event is taken at a time; req_ready is low from acceptance until the
// cycle after the event's last result has been loaded into the result register.
// A press first runs through the key-code pairs with a single shared comparator,
// one pair a cycle, stopping at the first hit. Results are then produced by
// scanning the mask bits, one bit position a cycle, up to the highest set bit,
// and a set bit waits while the result register is full and rsp_ready is low;
// the block then returns to idle. A release run is emitted on the first event
// after taps were applied; taps carry the key position, releases carry zero.
// Configuration is written through csr_we/csr_index/csr_wdata; the user must
// write it only while the block is idle, as the block does not enforce this.
module one_shot_modifier_key_filter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  oskf_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output oskf_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [oskf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [oskf_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   oskf_pkg::state_type                state_ff, state_in;
   logic [oskf_pkg::MASK_W-1:0]        pending_ff, pending_in;
   logic                               applied_ff, applied_in;
   logic [oskf_pkg::MASK_W-1:0]        work_mask_ff, work_mask_in;
   logic                               kind_ff, kind_in;
   logic [oskf_pkg::MOD_IDX_W-1:0]     bit_idx_ff, bit_idx_in;
   logic [oskf_pkg::KEY_W-1:0]         code_ff, code_in;
   logic [oskf_pkg::POS_W-1:0]         pos_ff, pos_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   oskf_pkg::rsp_type                  rsp_data_ff, rsp_data_in;
   logic [oskf_pkg::CNT_W-1:0]         pair_count_ff;
   logic [oskf_pkg::PAIR_REGS-1:0][oskf_pkg::PAIR_W-1:0] pair_ff;

   oskf_pkg::match_status_type         scan_status;
   logic                               req_accept;
   logic                               scan_start;
   logic                               out_free;
   logic                               rsp_load;
   logic [oskf_pkg::MASK_W-1:0]        bit_sel;
   logic [oskf_pkg::MASK_W-1:0]        rest_mask;
   logic                               tap_now;

   assign req_ready  = (state_ff == oskf_pkg::ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign scan_start = req_accept && req_data.is_press;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign bit_sel   = oskf_pkg::MASK_W'(1) << bit_idx_ff;
   assign rest_mask = work_mask_ff & ~bit_sel;
   assign rsp_load  = (state_ff == oskf_pkg::ST_EMIT) && ((work_mask_ff & bit_sel) != '0)
                      && out_free;

   // a press that did not match taps the pending mask if its key is tappable
   assign tap_now = !scan_status.found && (pending_ff != '0)
                    && (code_ff <= oskf_pkg::TAPPABLE_MAX);

   oskf_pair_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .start      (scan_start),
      .key_code   (req_data.key_code),
      .pair_count (pair_count_ff),
      .pair_word  (pair_ff),
      .status     (scan_status)
   );

   always_comb begin
      state_in     = state_ff;
      pending_in   = pending_ff;
      applied_in   = applied_ff;
      work_mask_in = work_mask_ff;
      kind_in      = kind_ff;
      bit_idx_in   = bit_idx_ff;
      code_in      = code_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         oskf_pkg::ST_IDLE: begin
            if (req_accept) begin
               code_in    = req_data.key_code;
               pos_in     = req_data.key_position;
               bit_idx_in = '0;
               kind_in    = oskf_pkg::ACT_RELEASE;
               if (applied_ff) begin
                  work_mask_in = pending_ff;
                  pending_in   = '0;
                  applied_in   = 1'b0;
               end else begin
                  work_mask_in = '0;
               end
               state_in = req_data.is_press ? oskf_pkg::ST_MATCH : oskf_pkg::ST_EMIT;
            end
         end
         oskf_pkg::ST_MATCH: begin
            if (scan_status.done) begin
               if (scan_status.found) begin
                  pending_in = pending_ff | scan_status.mask;
               end else if (tap_now) begin
                  // pending is nonzero only when no release run was loaded
                  work_mask_in = pending_ff;
                  kind_in      = oskf_pkg::ACT_TAP;
                  applied_in   = 1'b1;
               end
               state_in = oskf_pkg::ST_EMIT;
            end
         end
         oskf_pkg::ST_EMIT: begin
            if (work_mask_ff == '0) begin
               state_in = oskf_pkg::ST_IDLE;
            end else if ((work_mask_ff & bit_sel) == '0) begin
               bit_idx_in = bit_idx_ff + oskf_pkg::MOD_IDX_W'(1);
            end else if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.action_kind    = kind_ff;
               rsp_data_in.modifier_index = bit_idx_ff;
               rsp_data_in.tap_position   = (kind_ff == oskf_pkg::ACT_TAP) ? pos_ff : '0;
               rsp_data_in.last_of_run    = (rest_mask == '0);
               work_mask_in               = rest_mask;
               bit_idx_in                 = bit_idx_ff + oskf_pkg::MOD_IDX_W'(1);
            end
         end
         default: begin
            state_in = oskf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= oskf_pkg::ST_IDLE;
         pending_ff   <= '0;
         applied_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         work_mask_ff <= '0;
         bit_idx_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         applied_ff   <= applied_in;
         rsp_valid_ff <= rsp_valid_in;
         work_mask_ff <= work_mask_in;
         bit_idx_ff   <= bit_idx_in;
      end
      kind_ff     <= kind_in;
      code_ff     <= code_in;
      pos_ff      <= pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   // configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         pair_count_ff <= '0;
         pair_ff       <= '0;
      end else if (csr_we) begin
         if (csr_index == oskf_pkg::CSR_PAIR_COUNT) begin
            pair_count_ff <= csr_wdata[oskf_pkg::CNT_W-1:0];
         end
         for (int i = 0; i < oskf_pkg::PAIR_REGS; i++) begin
            if (csr_index == oskf_pkg::CSR_IDX_W'(int'(oskf_pkg::CSR_PAIR_BASE) + i)) begin
               pair_ff[i] <= csr_wdata[oskf_pkg::PAIR_W-1:0];
            end
         end
      end
   end

   // taps are only applied from a nonzero pending mask
   a_applied_mask: assert property (@(posedge clock) disable iff (reset)
      applied_ff |-> (pending_ff != '0))
      else $error("applied flag set with empty pending mask");

   // the pair scan reports only while the sequencer waits for it
   a_scan_done_state: assert property (@(posedge clock) disable iff (reset)
      scan_status.done |-> (state_ff == oskf_pkg::ST_MATCH))
      else $error("pair scan finished outside match state");

   // loading the last result of a run empties the working mask
   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && (rest_mask == '0)) |=> (work_mask_ff == '0))
      else $error("work mask not empty after last result");

   // a release run always follows clearing of the applied flag
   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == oskf_pkg::ST_EMIT && kind_ff == oskf_pkg::ACT_RELEASE) |-> !applied_ff)
      else $error("release run while applied flag still set");

endmodule
